### rtl/adaptive_playout_clock_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the adaptive playout clock unit
// Clocked implication checks, disabled while reset is low.
// ---------------------------------------------------------------------------
`ifndef ADAPTIVE_PLAYOUT_CLOCK_UNIT_MACROS_SVH
`define ADAPTIVE_PLAYOUT_CLOCK_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define APCU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define APCU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/apcu_pkg.sv
// ---------------------------------------------------------------------------
// apcu_pkg
// Widths, codes and reset values shared by the playout clock unit files.
// ---------------------------------------------------------------------------
`default_nettype none

package apcu_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int FRAME_W    = 32;
    localparam int POS_W      = FRAME_W + FRAC_BITS + 2;
    localparam int MAG_W      = POS_W - 1;
    localparam int GAIN_W     = 16;
    localparam int SNAP_W     = 24;
    localparam int DELAY_W    = 8;
    localparam int TICK_W     = 16;
    localparam int COUNT_W    = 32;
    localparam int SUB_W      = 8;
    localparam int CMD_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CMD_W-1:0] {
        CMD_ARRIVAL     = 3'd0,
        CMD_TICK        = 3'd1,
        CMD_RESTART     = 3'd2,
        CMD_FULL_RESET  = 3'd3,
        CMD_ROOM_CHANGE = 3'd4
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED   = 3'd0,
        CFG_MIN_DELAY = 3'd1,
        CFG_MAX_DELAY = 3'd2,
        CFG_GROW_COOL = 3'd3,
        CFG_SHRINK    = 3'd4,
        CFG_SNAP_ERR  = 3'd5,
        CFG_GAIN      = 3'd6
    } t_cfg_idx;

    localparam logic               ENABLED_RST   = 1'b1;
    localparam logic [DELAY_W-1:0] MIN_DELAY_RST = 8'd2;
    localparam logic [DELAY_W-1:0] MAX_DELAY_RST = 8'd12;
    localparam logic [TICK_W-1:0]  GROW_COOL_RST = 16'd60;
    localparam logic [TICK_W-1:0]  SHRINK_RST    = 16'd600;
    localparam logic [SNAP_W-1:0]  SNAP_ERR_RST  = 24'd655360;
    localparam logic [GAIN_W-1:0]  GAIN_RST      = 16'd3277;

    typedef logic signed [POS_W-1:0] t_pos;

    typedef struct packed {
        logic               ack_valid;
        logic [FRAME_W-1:0] ack_frame;
        logic [SUB_W-1:0]   ack_subframe;
        logic [DELAY_W-1:0] delay_now;
        logic               starved_now;
        logic               snapped_now;
        logic               clock_running;
        logic [COUNT_W-1:0] starve_total;
        logic [COUNT_W-1:0] snap_total;
    } t_result;

endpackage

`default_nettype wire

### rtl/adaptive_playout_clock_unit.sv
// ---------------------------------------------------------------------------
// Adaptive playout clock unit
// Jitter buffer playout clock: tracks the newest frame, steers a fixed-point
// read position toward newest minus delay and adapts the delay.
// ---------------------------------------------------------------------------
//   channel   direction  handshake                     payload
//   in        input      i_in_valid / o_in_ready       cmd, frame, session, client
//   out       output     o_out_valid / i_out_ready     ack point and status
//   cfg       input      i_cfg_wr_en                   i_cfg_index, i_cfg_data
//
// One item per cycle while o_in_ready is high; each item's result is registered.
// The whole state update (tick path: add, error, one 24x16 multiply, clamp)
// is combinational between the state registers, which sets the one-item-per-cycle rate.
// A two-entry output stage (result register plus skid) keeps o_in_ready
// registered; input stalls only when both entries are full.
// Synchronous active-low reset restores registers and state; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module adaptive_playout_clock_unit
    import apcu_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire [CMD_W-1:0]       i_cmd,
    input  wire [FRAME_W-1:0]     i_frame,
    input  wire                   i_session_active,
    input  wire                   i_is_client,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output logic                  o_ack_valid,
    output logic [FRAME_W-1:0]    o_ack_frame,
    output logic [SUB_W-1:0]      o_ack_subframe,
    output logic [DELAY_W-1:0]    o_delay_now,
    output logic                  o_starved_now,
    output logic                  o_snapped_now,
    output logic                  o_clock_running,
    output logic [COUNT_W-1:0]    o_starve_total,
    output logic [COUNT_W-1:0]    o_snap_total
);

    localparam t_pos ONE_FX  = t_pos'(1) <<< FRAC_BITS;
    localparam int   SNAP_UP = (FRAC_BITS >= 16) ? (FRAC_BITS - 16) : 0;
    localparam int   SNAP_DN = (FRAC_BITS < 16) ? (16 - FRAC_BITS) : 0;
    localparam int   CMP_W   = MAG_W + SNAP_W + 8;
    localparam int   CORR_W  = SNAP_W + SNAP_UP;
    localparam int   PROD_W  = CORR_W + GAIN_W;

    // configuration registers
    logic               r_enabled;
    logic [DELAY_W-1:0] r_min_delay;
    logic [DELAY_W-1:0] r_max_delay;
    logic [TICK_W-1:0]  r_grow_cool;
    logic [TICK_W-1:0]  r_shrink_after;
    logic [SNAP_W-1:0]  r_snap_err;
    logic [GAIN_W-1:0]  r_gain;

    // clock state
    logic               r_running,  n_running;
    logic [FRAME_W-1:0] r_newest,   n_newest;
    t_pos               r_pos,      n_pos;
    logic [DELAY_W-1:0] r_delay,    n_delay;
    logic [TICK_W-1:0]  r_tss,      n_tss;
    logic [TICK_W-1:0]  r_tsg,      n_tsg;
    logic [COUNT_W-1:0] r_starve,   n_starve;
    logic [COUNT_W-1:0] r_snap,     n_snap;
    logic               n_starved_now;
    logic               n_snapped_now;

    // output stage
    t_result            r_out;
    t_result            r_skid;
    logic               r_out_valid, n_out_valid;
    logic               r_skid_valid, n_skid_valid;
    t_result            res;

    logic               accept_in;
    logic               take_out;
    logic               load_out_res;
    logic               load_out_skid;
    logic               load_skid;

    // arrival path
    logic [FRAME_W-1:0] frame_diff;
    logic               arrival_newer;
    logic [FRAME_W-1:0] start_whole;
    t_pos               start_pos;

    // tick path
    logic                      tick_go;
    t_pos                      pos_inc;
    logic signed [FRAME_W+1:0] target_whole;
    t_pos                      target;
    t_pos                      err;
    logic                      err_neg;
    logic [MAG_W-1:0]          mag;
    logic [CMP_W-1:0]          mag_cmp;
    logic [CMP_W-1:0]          thr_cmp;
    logic                      snap_hit;
    logic [PROD_W-1:0]         prod;
    t_pos                      corr_pos;
    t_pos                      pos_adj;
    t_pos                      newest_fx;
    logic                      starve_hit;
    logic                      grow_ok;
    logic [TICK_W-1:0]         tss_inc;
    logic [TICK_W-1:0]         tsg_inc;
    logic                      shrink_ok;
    logic [COUNT_W-1:0]        starve_inc;
    logic [COUNT_W-1:0]        snap_inc;
    logic                      ack_ok;

    assign o_in_ready = !r_skid_valid;
    assign accept_in  = i_in_valid && o_in_ready;
    assign take_out   = r_out_valid && i_out_ready;

    // -- arrival ------------------------------------------------------------
    assign frame_diff    = i_frame - r_newest;
    assign arrival_newer = (frame_diff != '0) && !frame_diff[FRAME_W-1] && (i_frame > r_newest);
    assign start_whole   = (i_frame > FRAME_W'(r_delay)) ? (i_frame - FRAME_W'(r_delay))
                                                         : i_frame;
    assign start_pos     = t_pos'(POS_W'(start_whole) << FRAC_BITS);

    // -- tick ---------------------------------------------------------------
    assign tick_go      = r_enabled && i_session_active && r_running;
    assign pos_inc      = r_pos + ONE_FX;
    assign target_whole = $signed({2'b00, r_newest}) - $signed((FRAME_W + 2)'(r_delay));
    assign target       = t_pos'(target_whole) <<< FRAC_BITS;
    assign err          = target - pos_inc;
    assign err_neg      = err[POS_W-1];
    assign mag          = err_neg ? MAG_W'(-err) : MAG_W'(err);

    // rescale the Q.16 threshold to the position's fraction width
    assign mag_cmp  = CMP_W'(mag) << SNAP_DN;
    assign thr_cmp  = CMP_W'(r_snap_err) << SNAP_UP;
    assign snap_hit = mag_cmp > thr_cmp;

    // correction truncates toward zero: scale the magnitude, then apply sign;
    // without a snap the magnitude fits the threshold width
    assign prod     = PROD_W'(mag[CORR_W-1:0]) * PROD_W'(r_gain);
    assign corr_pos = t_pos'(prod[GAIN_W +: CORR_W]);
    assign pos_adj  = snap_hit ? target
                    : (err_neg ? (pos_inc - corr_pos) : (pos_inc + corr_pos));

    assign newest_fx  = t_pos'(POS_W'(r_newest) << FRAC_BITS);
    assign starve_hit = pos_adj > newest_fx;
    assign grow_ok    = (r_delay < r_max_delay) && (r_tsg >= r_grow_cool);
    assign tss_inc    = (r_tss == '1) ? r_tss : (r_tss + 1'b1);
    assign tsg_inc    = (r_tsg == '1) ? r_tsg : (r_tsg + 1'b1);
    assign shrink_ok  = (tss_inc > r_shrink_after) && (r_delay > r_min_delay);
    assign starve_inc = (r_starve == '1) ? r_starve : (r_starve + 1'b1);
    assign snap_inc   = (r_snap == '1) ? r_snap : (r_snap + 1'b1);

    always_comb begin
        n_running     = r_running;
        n_newest      = r_newest;
        n_pos         = r_pos;
        n_delay       = r_delay;
        n_tss         = r_tss;
        n_tsg         = r_tsg;
        n_starve      = r_starve;
        n_snap        = r_snap;
        n_starved_now = 1'b0;
        n_snapped_now = 1'b0;
        unique case (t_cmd'(i_cmd))
            CMD_ARRIVAL: begin
                if (r_enabled && (i_frame != '0)) begin
                    if (r_running) begin
                        if (arrival_newer) begin
                            n_newest = i_frame;
                        end
                    end else begin
                        n_newest  = i_frame;
                        n_running = 1'b1;
                        n_pos     = start_pos;
                    end
                end
            end
            CMD_TICK: begin
                if (tick_go) begin
                    n_pos = pos_adj;
                    if (snap_hit) begin
                        n_snap        = snap_inc;
                        n_snapped_now = 1'b1;
                    end
                    n_tsg = tsg_inc;
                    if (starve_hit) begin
                        // pin at newest; grow the delay once the cooldown has passed
                        n_pos         = newest_fx;
                        n_starve      = starve_inc;
                        n_tss         = '0;
                        n_starved_now = 1'b1;
                        if (grow_ok) begin
                            n_delay = r_delay + 1'b1;
                            n_tsg   = TICK_W'(1);
                        end
                    end else if (shrink_ok) begin
                        n_delay = r_delay - 1'b1;
                        n_tss   = '0;
                    end else begin
                        n_tss = tss_inc;
                    end
                end
            end
            CMD_RESTART: begin
                n_newest  = '0;
                n_running = 1'b0;
                n_tss     = '0;
                n_tsg     = r_grow_cool;
            end
            CMD_FULL_RESET: begin
                n_running = 1'b0;
                n_newest  = '0;
                n_pos     = '0;
                n_delay   = r_min_delay;
                n_tss     = '0;
                n_tsg     = r_grow_cool;
                n_starve  = '0;
                n_snap    = '0;
            end
            CMD_ROOM_CHANGE: begin
                n_newest  = '0;
                n_pos     = '0;
                n_running = 1'b0;
                n_tsg     = r_grow_cool;
            end
            default: begin
                // unknown command: hold state
            end
        endcase
    end

    // -- result -------------------------------------------------------------
    assign ack_ok = r_enabled && i_session_active && i_is_client && n_running
                 && (n_pos >= ONE_FX);

    always_comb begin
        res.ack_valid     = ack_ok;
        res.ack_frame     = ack_ok ? n_pos[FRAC_BITS +: FRAME_W] : '0;
        res.ack_subframe  = ack_ok ? n_pos[FRAC_BITS-SUB_W +: SUB_W] : '0;
        res.delay_now     = n_delay;
        res.starved_now   = n_starved_now;
        res.snapped_now   = n_snapped_now;
        res.clock_running = n_running;
        res.starve_total  = n_starve;
        res.snap_total    = n_snap;
    end

    // -- output stage control -----------------------------------------------
    always_comb begin
        n_out_valid   = r_out_valid;
        n_skid_valid  = r_skid_valid;
        load_out_res  = 1'b0;
        load_out_skid = 1'b0;
        load_skid     = 1'b0;
        if (take_out || !r_out_valid) begin
            if (r_skid_valid) begin
                load_out_skid = 1'b1;
                n_out_valid   = 1'b1;
                n_skid_valid  = 1'b0;
            end else if (accept_in) begin
                load_out_res = 1'b1;
                n_out_valid  = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (accept_in) begin
            // result register is held: park the item in the skid entry
            load_skid    = 1'b1;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out_skid) begin
            r_out <= r_skid;
        end else if (load_out_res) begin
            r_out <= res;
        end
        if (load_skid) begin
            r_skid <= res;
        end
    end

    // -- configuration ------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled      <= ENABLED_RST;
            r_min_delay    <= MIN_DELAY_RST;
            r_max_delay    <= MAX_DELAY_RST;
            r_grow_cool    <= GROW_COOL_RST;
            r_shrink_after <= SHRINK_RST;
            r_snap_err     <= SNAP_ERR_RST;
            r_gain         <= GAIN_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ENABLED:   r_enabled      <= i_cfg_data[0];
                CFG_MIN_DELAY: r_min_delay    <= i_cfg_data[DELAY_W-1:0];
                CFG_MAX_DELAY: r_max_delay    <= i_cfg_data[DELAY_W-1:0];
                CFG_GROW_COOL: r_grow_cool    <= i_cfg_data[TICK_W-1:0];
                CFG_SHRINK:    r_shrink_after <= i_cfg_data[TICK_W-1:0];
                CFG_SNAP_ERR:  r_snap_err     <= i_cfg_data[SNAP_W-1:0];
                CFG_GAIN:      r_gain         <= i_cfg_data[GAIN_W-1:0];
                default: begin
                    // index beyond the register list: drop the write
                end
            endcase
        end
    end

    // -- clock state --------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_newest  <= '0;
            r_pos     <= '0;
            r_delay   <= MIN_DELAY_RST;
            r_tss     <= '0;
            r_tsg     <= GROW_COOL_RST;
            r_starve  <= '0;
            r_snap    <= '0;
        end else if (accept_in) begin
            r_running <= n_running;
            r_newest  <= n_newest;
            r_pos     <= n_pos;
            r_delay   <= n_delay;
            r_tss     <= n_tss;
            r_tsg     <= n_tsg;
            r_starve  <= n_starve;
            r_snap    <= n_snap;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_ack_valid     = r_out.ack_valid;
    assign o_ack_frame     = r_out.ack_frame;
    assign o_ack_subframe  = r_out.ack_subframe;
    assign o_delay_now     = r_out.delay_now;
    assign o_starved_now   = r_out.starved_now;
    assign o_snapped_now   = r_out.snapped_now;
    assign o_clock_running = r_out.clock_running;
    assign o_starve_total  = r_out.starve_total;
    assign o_snap_total    = r_out.snap_total;

endmodule

`default_nettype wire

### rtl/apcu_checker.sv
// ---------------------------------------------------------------------------
// apcu_checker
// Port-level checks on the playout clock unit's result channel.
// ---------------------------------------------------------------------------
`default_nettype none

`include "adaptive_playout_clock_unit_macros.svh"

module apcu_checker
    import apcu_pkg::*;
(
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               o_out_valid,
    input wire               i_out_ready,
    input wire               o_ack_valid,
    input wire [FRAME_W-1:0] o_ack_frame,
    input wire [SUB_W-1:0]   o_ack_subframe,
    input wire               o_starved_now,
    input wire               o_snapped_now,
    input wire               o_clock_running
);

    // an invalid ack point carries zeros
    `APCU_ASSERT_NOW(a_ack_zero, i_clk, i_rst_n,
        o_out_valid && !o_ack_valid,
        (o_ack_frame == '0) && (o_ack_subframe == '0),
        "invalid ack with nonzero point")

    // the ack needs a running clock and a whole frame of at least one
    `APCU_ASSERT_NOW(a_ack_running, i_clk, i_rst_n,
        o_out_valid && o_ack_valid,
        o_clock_running && (o_ack_frame != '0),
        "ack without running clock")

    // a snap lands on newest minus delay, which can never starve
    `APCU_ASSERT_NOW(a_snap_no_starve, i_clk, i_rst_n,
        o_out_valid,
        !(o_starved_now && o_snapped_now),
        "tick both snapped and starved")

    // a stalled result holds
    `APCU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_ack_frame) && $stable(o_ack_valid),
        "stalled result changed")

endmodule

bind adaptive_playout_clock_unit apcu_checker u_apcu_checker (.*);

`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Playout clock unit testbench
// Drives arrival, tick and control items through the valid/ready input with
// random sender gaps and receiver stalls. A scoreboard class predicts the
// ack point and status for every accepted item and checks each result in
// order. Register settings change between phases, only while the unit is
// idle.
// ---------------------------------------------------------------------------

module tb;
    import apcu_pkg::*;

    localparam longint ONE_FX  = longint'(1) << FRAC_BITS;
    localparam int     SNAP_UP = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int     SNAP_DN = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    class playout_checker;
        logic               reg_en;
        logic [DELAY_W-1:0] reg_min;
        logic [DELAY_W-1:0] reg_max;
        logic [TICK_W-1:0]  reg_cool;
        logic [TICK_W-1:0]  reg_shrink;
        logic [SNAP_W-1:0]  reg_snap;
        logic [GAIN_W-1:0]  reg_gain;

        logic               running;
        logic [FRAME_W-1:0] newest;
        t_pos               pos;
        logic [DELAY_W-1:0] delay;
        logic [TICK_W-1:0]  since_starved;
        logic [TICK_W-1:0]  since_grew;
        logic [COUNT_W-1:0] starves;
        logic [COUNT_W-1:0] snaps;

        t_result acks_due[$];
        int      mismatches;

        function new();
            reg_en     = ENABLED_RST;
            reg_min    = MIN_DELAY_RST;
            reg_max    = MAX_DELAY_RST;
            reg_cool   = GROW_COOL_RST;
            reg_shrink = SHRINK_RST;
            reg_snap   = SNAP_ERR_RST;
            reg_gain   = GAIN_RST;
            mismatches = 0;
            clear_all();
        endfunction

        function void clear_all();
            running       = 1'b0;
            newest        = '0;
            pos           = '0;
            delay         = reg_min;
            since_starved = '0;
            since_grew    = reg_cool;
            starves       = '0;
            snaps         = '0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_ENABLED:   reg_en     = val[0];
                CFG_MIN_DELAY: reg_min    = val[DELAY_W-1:0];
                CFG_MAX_DELAY: reg_max    = val[DELAY_W-1:0];
                CFG_GROW_COOL: reg_cool   = val[TICK_W-1:0];
                CFG_SHRINK:    reg_shrink = val[TICK_W-1:0];
                CFG_SNAP_ERR:  reg_snap   = val[SNAP_W-1:0];
                CFG_GAIN:      reg_gain   = val[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the predicted clock by one accepted item and queue its ack.
        function void take_item(logic [CMD_W-1:0] cmd, logic [FRAME_W-1:0] frame,
                                logic act, logic cli);
            logic               starved;
            logic               snapped;
            logic               hit;
            logic [FRAME_W-1:0] ahead;
            longint             p;
            longint             tgt;
            longint             err;
            longint             nfx;
            logic [63:0]        mag;
            logic [63:0]        corr;
            logic [63:0]        up;
            t_result            r;

            starved = 1'b0;
            snapped = 1'b0;
            case (cmd)
                CMD_ARRIVAL: begin
                    if (reg_en && frame != '0) begin
                        if (running) begin
                            // count only frames ahead by less than half the range
                            ahead = frame - newest;
                            if (ahead != '0 && !ahead[FRAME_W-1] && frame > newest)
                                newest = frame;
                        end else begin
                            newest  = frame;
                            running = 1'b1;
                            if (frame > FRAME_W'(delay))
                                pos = t_pos'((longint'(frame) - longint'(delay)) * ONE_FX);
                            else
                                pos = t_pos'(longint'(frame) * ONE_FX);
                        end
                    end
                end
                CMD_TICK: begin
                    if (reg_en && act && running) begin
                        p   = longint'(pos) + ONE_FX;
                        tgt = (longint'(newest) - longint'(delay)) * ONE_FX;
                        err = tgt - p;
                        mag = (err < 0) ? 64'(-err) : 64'(err);
                        if (FRAC_BITS >= 16)
                            hit = mag > (64'(reg_snap) << SNAP_UP);
                        else
                            hit = (mag << SNAP_DN) > 64'(reg_snap);
                        if (hit) begin
                            p       = tgt;
                            snapped = 1'b1;
                            if (snaps != '1) snaps++;
                        end else begin
                            corr = (mag * 64'(reg_gain)) >> 16;
                            if (err < 0) p = p - longint'(corr);
                            else         p = p + longint'(corr);
                        end
                        nfx = longint'(newest) * ONE_FX;
                        if (p > nfx) begin
                            // pin at the newest frame
                            p             = nfx;
                            starved       = 1'b1;
                            since_starved = '0;
                            if (starves != '1) starves++;
                            if (delay < reg_max && since_grew >= reg_cool) begin
                                delay++;
                                since_grew = '0;
                            end
                        end else begin
                            if (since_starved != '1) since_starved++;
                            if (since_starved > reg_shrink && delay > reg_min) begin
                                delay--;
                                since_starved = '0;
                            end
                        end
                        if (since_grew != '1) since_grew++;
                        pos = t_pos'(p);
                    end
                end
                CMD_RESTART: begin
                    newest        = '0;
                    running       = 1'b0;
                    since_starved = '0;
                    since_grew    = reg_cool;
                end
                CMD_FULL_RESET: clear_all();
                CMD_ROOM_CHANGE: begin
                    newest     = '0;
                    pos        = '0;
                    running    = 1'b0;
                    since_grew = reg_cool;
                end
                default: ;
            endcase

            r = '0;
            if (reg_en && act && cli && running && longint'(pos) >= ONE_FX) begin
                up             = 64'(longint'(pos));
                r.ack_valid    = 1'b1;
                r.ack_frame    = up[FRAC_BITS +: FRAME_W];
                r.ack_subframe = up[FRAC_BITS-SUB_W +: SUB_W];
            end
            r.delay_now     = delay;
            r.starved_now   = starved;
            r.snapped_now   = snapped;
            r.clock_running = running;
            r.starve_total  = starves;
            r.snap_total    = snaps;
            acks_due.push_back(r);
        endfunction

        function void cmp(string fld, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fld, want, got);
                mismatches++;
            end
        endfunction

        function void check_ack(t_result got);
            t_result want;
            if (acks_due.size() == 0) begin
                $display("%0t: result with no item pending: expected none, actual %h",
                         $time, got);
                mismatches++;
                return;
            end
            want = acks_due.pop_front();
            cmp("ack_valid", want.ack_valid, got.ack_valid);
            cmp("ack_frame", want.ack_frame, got.ack_frame);
            cmp("ack_subframe", want.ack_subframe, got.ack_subframe);
            cmp("delay_now", want.delay_now, got.delay_now);
            cmp("starved_now", want.starved_now, got.starved_now);
            cmp("snapped_now", want.snapped_now, got.snapped_now);
            cmp("clock_running", want.clock_running, got.clock_running);
            cmp("starve_total", want.starve_total, got.starve_total);
            cmp("snap_total", want.snap_total, got.snap_total);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [CMD_W-1:0]      i_cmd = '0;
    logic [FRAME_W-1:0]    i_frame = '0;
    logic                  i_session_active = 1'b0;
    logic                  i_is_client = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_ack_valid;
    logic [FRAME_W-1:0]    o_ack_frame;
    logic [SUB_W-1:0]      o_ack_subframe;
    logic [DELAY_W-1:0]    o_delay_now;
    logic                  o_starved_now;
    logic                  o_snapped_now;
    logic                  o_clock_running;
    logic [COUNT_W-1:0]    o_starve_total;
    logic [COUNT_W-1:0]    o_snap_total;

    playout_checker     sb = new();
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    logic [FRAME_W-1:0] stream_frame = 32'd1;

    adaptive_playout_clock_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_frame          (i_frame),
        .i_session_active (i_session_active),
        .i_is_client      (i_is_client),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_ack_valid      (o_ack_valid),
        .o_ack_frame      (o_ack_frame),
        .o_ack_subframe   (o_ack_subframe),
        .o_delay_now      (o_delay_now),
        .o_starved_now    (o_starved_now),
        .o_snapped_now    (o_snapped_now),
        .o_clock_running  (o_clock_running),
        .o_starve_total   (o_starve_total),
        .o_snap_total     (o_snap_total)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Handshakes are sampled with the values in place before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.take_item(i_cmd, i_frame, i_session_active, i_is_client);
            if (o_out_valid && i_out_ready)
                sb.check_ack({o_ack_valid, o_ack_frame, o_ack_subframe, o_delay_now,
                              o_starved_now, o_snapped_now, o_clock_running,
                              o_starve_total, o_snap_total});
        end
    end

    task automatic send_item(logic [CMD_W-1:0] cmd, logic [FRAME_W-1:0] frame,
                             logic act, logic cli);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid       <= 1'b1;
        i_cmd            <= cmd;
        i_frame          <= frame;
        i_session_active <= act;
        i_is_client      <= cli;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Hold the sender until every queued ack has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (sb.acks_due.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic set_regs(logic en, logic [DELAY_W-1:0] mn, logic [DELAY_W-1:0] mx,
                            logic [TICK_W-1:0] cool, logic [TICK_W-1:0] shr,
                            logic [SNAP_W-1:0] snap, logic [GAIN_W-1:0] gain);
        write_reg(CFG_ENABLED, CFG_DATA_W'(en));
        write_reg(CFG_MIN_DELAY, CFG_DATA_W'(mn));
        write_reg(CFG_MAX_DELAY, CFG_DATA_W'(mx));
        write_reg(CFG_GROW_COOL, CFG_DATA_W'(cool));
        write_reg(CFG_SHRINK, CFG_DATA_W'(shr));
        write_reg(CFG_SNAP_ERR, CFG_DATA_W'(snap));
        write_reg(CFG_GAIN, CFG_DATA_W'(gain));
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly an in-order frame stream with ticks; some noise and control items.
    task automatic send_random();
        int                 r;
        int                 s;
        logic [CMD_W-1:0]   cmd;
        logic [FRAME_W-1:0] frame;
        logic               act;
        logic               cli;

        r     = $urandom_range(0, 99);
        act   = ($urandom_range(0, 9) != 0);
        cli   = ($urandom_range(0, 6) != 0);
        frame = $urandom();
        if (r < 36) begin
            cmd = CMD_ARRIVAL;
            s   = $urandom_range(0, 19);
            if (s == 0) begin
                frame = '0;
            end else if (s == 1) begin
                frame = $urandom();
            end else if (s == 2) begin
                frame = stream_frame - $urandom_range(0, 3);
            end else begin
                stream_frame = stream_frame + $urandom_range(1, 2);
                frame        = stream_frame;
            end
        end else if (r < 90) begin
            cmd = CMD_TICK;
        end else if (r < 98) begin
            if (r < 93)      cmd = CMD_RESTART;
            else if (r < 96) cmd = CMD_ROOM_CHANGE;
            else             cmd = CMD_FULL_RESET;
            // restart the frame stream, sometimes just below the wrap point
            s = $urandom_range(0, 3);
            if (s == 0)      stream_frame = 32'hFFFF_FFF0 + $urandom_range(0, 8);
            else if (s == 1) stream_frame = $urandom();
            else             stream_frame = $urandom_range(1, 300);
        end else begin
            cmd = CMD_W'($urandom_range(5, 7));
        end
        send_item(cmd, frame, act, cli);
        if ($urandom_range(0, 59) == 0) wait_drained();
    endtask

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int phase;
        int count;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed items on the reset settings
        send_item(CMD_TICK, 32'd7, 1'b1, 1'b1);
        send_item(CMD_ARRIVAL, 32'd0, 1'b1, 1'b1);
        send_item(CMD_ARRIVAL, 32'd1, 1'b1, 1'b1);
        send_item(CMD_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_item(CMD_ARRIVAL, 32'h8000_0000, 1'b1, 1'b1);
        send_item(CMD_TICK, 32'd0, 1'b1, 1'b1);
        send_item(CMD_ARRIVAL, 32'h7FFF_FFFF, 1'b1, 1'b1);
        send_item(CMD_ARRIVAL, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_item(CMD_TICK, 32'd0, 1'b0, 1'b1);
        send_item(CMD_TICK, 32'd0, 1'b1, 1'b0);
        send_item(CMD_ARRIVAL, 32'd5, 1'b1, 1'b1);
        send_item(CMD_TICK, 32'd0, 1'b1, 1'b1);
        send_item(CMD_W'(5), 32'h5555_5555, 1'b1, 1'b1);
        send_item(CMD_W'(6), 32'hAAAA_AAAA, 1'b1, 1'b1);
        send_item(CMD_W'(7), 32'hFFFF_FFFF, 1'b0, 1'b0);
        send_item(CMD_RESTART, 32'd0, 1'b1, 1'b1);
        send_item(CMD_ARRIVAL, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_item(CMD_TICK, 32'd0, 1'b1, 1'b1);
        send_item(CMD_ROOM_CHANGE, 32'd0, 1'b1, 1'b1);
        send_item(CMD_TICK, 32'd0, 1'b1, 1'b1);
        send_item(CMD_FULL_RESET, 32'd0, 1'b1, 1'b1);
        send_item(CMD_ARRIVAL, 32'd2, 1'b1, 1'b1);
        send_item(CMD_TICK, 32'd0, 1'b1, 1'b1);
        send_item(CMD_TICK, 32'd0, 1'b1, 1'b1);
        wait_drained();

        for (phase = 0; phase < 8; phase++) begin
            count = 55;
            case (phase)
                0: ;
                1: set_regs(1'b1, 8'd0, 8'd255, 16'd0, 16'd0, 24'd0, 16'hFFFF);
                2: begin
                    set_regs(1'b0, DELAY_W'($urandom_range(0, 255)),
                             DELAY_W'($urandom_range(0, 255)),
                             TICK_W'($urandom()), TICK_W'($urandom()),
                             SNAP_W'($urandom()), GAIN_W'($urandom()));
                    count = 20;
                end
                3: set_regs(1'b1, 8'd255, 8'd0, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 16'd0);
                5: set_regs(1'b1, 8'd1, 8'd8, 16'd4, 16'd12, 24'(3 << 16), 16'd16384);
                default: begin
                    count = $urandom_range(0, 6);
                    set_regs(1'b1, DELAY_W'(count),
                             DELAY_W'(count + $urandom_range(0, 10)),
                             TICK_W'($urandom_range(0, 30)),
                             TICK_W'($urandom_range(0, 50)),
                             SNAP_W'($urandom_range(0, 6 << 16)),
                             GAIN_W'($urandom()));
                    count = 50;
                end
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 78; end
                default: begin send_idle_pct = 21; recv_stall_pct <= 21; end
            endcase
            repeat (count) send_random();
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.acks_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/apcu_pkg.sv
rtl/adaptive_playout_clock_unit.sv
rtl/apcu_checker.sv
test/tb.sv
